FILE: src/tdns_pkg.sv
package tdns_pkg;

  localparam int unsigned HIST_W    = 24;
  localparam int unsigned COEF_W    = 14;
  localparam int unsigned DITH_W    = 17;
  localparam int unsigned DRAW_W    = 16;
  localparam int unsigned FB_W      = 32;
  localparam int unsigned LCG_W     = 32;
  localparam int unsigned ORDER_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [LCG_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [LCG_W-1:0] LCG_INC = 32'd1013904223;

  localparam logic signed [HIST_W-1:0] ERR_CLAMP_HI = 24'sd65536;
  localparam logic signed [HIST_W-1:0] ERR_CLAMP_LO = -24'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DITHER_KIND   = 2'd0,
    CFG_SHAPING_ORDER = 2'd1,
    CFG_NOISE_SEED    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DK_NONE   = 2'd0,
    DK_RECT   = 2'd1,
    DK_TRI    = 2'd2,
    DK_HP_TRI = 2'd3
  } dither_kind_e;

  typedef struct packed {
    logic clear;
    logic push;
    logic rotate;
    logic coef_clr;
    logic coef_step;
  } cell_ctrl_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic draw1;
    logic draw2;
  } dith_ctrl_t;

endpackage

FILE: src/tpdf_dither_noise_shaper.sv
// Channel  Direction  Handshake                  Word
// in       sink       in_valid_i / in_stall_o    restart, has_error, quant_error, was_clipped
// out      source     out_valid_o / out_stall_i  dither_value, shaping_feedback
// cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// A word is accepted, then taken through a multiply-accumulate pass that rotates the
// history cells past one multiplier, and then loaded into the output register. After a
// write to the shaping order, the next word first builds the binomial taps in the cells.
// Reset clears the history, taps, generator, shaping order, seed and output valid, and
// sets the dither kind to triangular.
// A new word is taken while a finished word waits; a stalled output holds the block
// at the end of its next word.
module tpdf_dither_noise_shaper #(
  parameter int unsigned MAX_ORDER = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     restart_i,
  input  logic                                     has_error_i,
  input  logic signed [tdns_pkg::HIST_W-1:0]       quant_error_i,
  input  logic                                     was_clipped_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [tdns_pkg::DITH_W-1:0]       dither_value_o,
  output logic signed [tdns_pkg::FB_W-1:0]         shaping_feedback_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic        [tdns_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic        [tdns_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int unsigned N_W    = $clog2(MAX_ORDER + 1);
  localparam int unsigned OW     = (N_W > tdns_pkg::ORDER_W) ? N_W : tdns_pkg::ORDER_W;
  localparam int unsigned PROD_W = tdns_pkg::HIST_W + tdns_pkg::COEF_W + 1;
  localparam int unsigned ACC_W  = PROD_W + N_W;
  localparam int unsigned HW     = tdns_pkg::HIST_W;
  localparam int unsigned CW     = tdns_pkg::COEF_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COEF = 4'b0010,
    ST_MAC  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [N_W-1:0]                  cnt_q, cnt_d;
  logic                            dirty_q, dirty_d;
  tdns_pkg::dither_kind_e          kind_q;
  logic [tdns_pkg::ORDER_W-1:0]    order_q;
  logic [tdns_pkg::LCG_W-1:0]      seed_q;
  logic [OW-1:0]                   order_x;
  logic [N_W-1:0]                  n_act;

  logic                            accept, out_load;
  tdns_pkg::cell_ctrl_t            cctl;
  tdns_pkg::dith_ctrl_t            dctl;
  logic signed [HW-1:0]            err_clamped;

  logic signed [HW-1:0]            h_w     [MAX_ORDER];
  logic signed [HW-1:0]            h_left  [MAX_ORDER];
  logic signed [HW-1:0]            h_right [MAX_ORDER];
  logic        [CW-1:0]            c_w     [MAX_ORDER];
  logic        [CW-1:0]            c_left  [MAX_ORDER];
  logic        [CW-1:0]            c_right [MAX_ORDER];

  logic signed [CW:0]              c_pos, c_sgn;
  logic signed [PROD_W-1:0]        prod_q, prod_d;
  logic signed [ACC_W-1:0]         acc_q, acc_d;
  logic signed [tdns_pkg::FB_W-1:0] fb_sat;
  logic signed [tdns_pkg::DITH_W-1:0] dith_w;
  logic                            out_valid_q;
  logic signed [tdns_pkg::DITH_W-1:0] dith_out_q;
  logic signed [tdns_pkg::FB_W-1:0]   fb_out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= tdns_pkg::DK_TRI;
      order_q <= '0;
      seed_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tdns_pkg::CFG_DITHER_KIND: begin
          kind_q <= tdns_pkg::dither_kind_e'(cfg_data_i[1:0]);
        end
        tdns_pkg::CFG_SHAPING_ORDER: begin
          order_q <= cfg_data_i[tdns_pkg::ORDER_W-1:0];
        end
        tdns_pkg::CFG_NOISE_SEED: begin
          seed_q <= cfg_data_i[tdns_pkg::LCG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign order_x = OW'(order_q);
  assign n_act   = (order_x > OW'(MAX_ORDER)) ? N_W'(MAX_ORDER) : N_W'(order_x);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    err_clamped = quant_error_i;
    if (was_clipped_i) begin
      if (quant_error_i > tdns_pkg::ERR_CLAMP_HI) begin
        err_clamped = tdns_pkg::ERR_CLAMP_HI;
      end else if (quant_error_i < tdns_pkg::ERR_CLAMP_LO) begin
        err_clamped = tdns_pkg::ERR_CLAMP_LO;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dirty_d = dirty_q;
    cctl    = '0;
    dctl    = '0;
    if (cfg_valid_i && (cfg_index_i == tdns_pkg::CFG_SHAPING_ORDER)) begin
      dirty_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cctl.clear    = restart_i;
          cctl.push     = has_error_i && (n_act != '0);
          cctl.coef_clr = dirty_q;
          dctl.load     = 1'b1;
          dctl.restart  = restart_i;
          cnt_d         = '0;
          state_d       = dirty_q ? ST_COEF : ST_MAC;
        end
      end
      ST_COEF: begin
        if (cnt_q == n_act) begin
          cnt_d   = '0;
          dirty_d = 1'b0;
          state_d = ST_MAC;
        end else begin
          cctl.coef_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      ST_MAC: begin
        dctl.draw1 = (cnt_q == '0) && (kind_q != tdns_pkg::DK_NONE);
        dctl.draw2 = (cnt_q == N_W'(1)) && (kind_q == tdns_pkg::DK_TRI);
        if (cnt_q == N_W'(MAX_ORDER)) begin
          state_d = ST_FIN;
        end else begin
          cctl.rotate = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dirty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dirty_q <= dirty_d;
    end
  end

  for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign h_left[g] = err_clamped;
      assign c_left[g] = CW'(1);
    end else begin : g_body
      assign h_left[g] = cctl.clear ? '0 : h_w[g-1];
      assign c_left[g] = c_w[g-1];
    end
    if (g == MAX_ORDER - 1) begin : g_tail
      assign h_right[g] = h_w[0];
      assign c_right[g] = c_w[0];
    end else begin : g_inner
      assign h_right[g] = h_w[g+1];
      assign c_right[g] = c_w[g+1];
    end

    tdns_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cctl),
      .h_left_i  (h_left[g]),
      .h_right_i (h_right[g]),
      .c_left_i  (c_left[g]),
      .c_right_i (c_right[g]),
      .h_o       (h_w[g]),
      .c_o       (c_w[g])
    );
  end

  tdns_dither u_dither (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dctl),
    .kind_i  (kind_q),
    .seed_i  (seed_q),
    .value_o (dith_w)
  );

  assign c_pos  = $signed({1'b0, c_w[0]});
  assign c_sgn  = cnt_q[0] ? c_pos : -c_pos;
  assign prod_d = h_w[0] * c_sgn;

  always_comb begin
    acc_d = acc_q;
    if (state_q == ST_IDLE) begin
      acc_d = '0;
    end else if ((state_q == ST_MAC) && (cnt_q != '0)) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    if ((&acc_q[ACC_W-1:tdns_pkg::FB_W-1]) || !(|acc_q[ACC_W-1:tdns_pkg::FB_W-1])) begin
      fb_sat = acc_q[tdns_pkg::FB_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      fb_sat = {1'b1, {(tdns_pkg::FB_W-1){1'b0}}};
    end else begin
      fb_sat = {1'b0, {(tdns_pkg::FB_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dith_out_q <= dith_w;
      fb_out_q   <= fb_sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign dither_value_o     = dith_out_q;
  assign shaping_feedback_o = fb_out_q;

`ifndef SYNTHESIS
  a_rose_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("output valid rose without a finished word");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted word did not start processing");

  a_mac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (cnt_q <= N_W'(MAX_ORDER)))
    else $error("tap counter ran past the chain length");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_stall_i) |=> out_valid_o)
    else $error("finished word was not presented");
`endif

endmodule

FILE: src/tdns_cell.sv
module tdns_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tdns_pkg::cell_ctrl_t                  ctrl_i,
  input  logic signed [tdns_pkg::HIST_W-1:0]    h_left_i,
  input  logic signed [tdns_pkg::HIST_W-1:0]    h_right_i,
  input  logic        [tdns_pkg::COEF_W-1:0]    c_left_i,
  input  logic        [tdns_pkg::COEF_W-1:0]    c_right_i,
  output logic signed [tdns_pkg::HIST_W-1:0]    h_o,
  output logic        [tdns_pkg::COEF_W-1:0]    c_o
);

  logic signed [tdns_pkg::HIST_W-1:0] h_q, h_d;
  logic        [tdns_pkg::COEF_W-1:0] c_q, c_d;

  always_comb begin
    h_d = h_q;
    if (ctrl_i.push) begin
      h_d = h_left_i;
    end else if (ctrl_i.clear) begin
      h_d = '0;
    end else if (ctrl_i.rotate) begin
      h_d = h_right_i;
    end
  end

  always_comb begin
    c_d = c_q;
    if (ctrl_i.coef_clr) begin
      c_d = '0;
    end else if (ctrl_i.coef_step) begin
      c_d = c_q + c_left_i;
    end else if (ctrl_i.rotate) begin
      c_d = c_right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
      c_q <= '0;
    end else begin
      h_q <= h_d;
      c_q <= c_d;
    end
  end

  assign h_o = h_q;
  assign c_o = c_q;

endmodule

FILE: src/tdns_dither.sv
module tdns_dither (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tdns_pkg::dith_ctrl_t                  ctrl_i,
  input  tdns_pkg::dither_kind_e                kind_i,
  input  logic        [tdns_pkg::LCG_W-1:0]     seed_i,
  output logic signed [tdns_pkg::DITH_W-1:0]    value_o
);

  logic        [tdns_pkg::LCG_W-1:0]  lcg_q, lcg_d, lcg_step;
  logic signed [tdns_pkg::DRAW_W-1:0] last_q, last_d, draw;
  logic signed [tdns_pkg::DITH_W-1:0] val_q, val_d, draw_x, last_x;

  assign lcg_step = lcg_q * tdns_pkg::LCG_MUL + tdns_pkg::LCG_INC;
  assign draw     = $signed({~lcg_step[tdns_pkg::LCG_W-1],
                             lcg_step[tdns_pkg::LCG_W-2:tdns_pkg::LCG_W-tdns_pkg::DRAW_W]});
  assign draw_x   = {draw[tdns_pkg::DRAW_W-1], draw};
  assign last_x   = {last_q[tdns_pkg::DRAW_W-1], last_q};

  always_comb begin
    lcg_d  = lcg_q;
    last_d = last_q;
    val_d  = val_q;
    if (ctrl_i.load) begin
      val_d = '0;
      if (ctrl_i.restart) begin
        lcg_d  = seed_i;
        last_d = '0;
      end
    end else if (ctrl_i.draw1) begin
      lcg_d = lcg_step;
      if (kind_i == tdns_pkg::DK_HP_TRI) begin
        val_d  = draw_x - last_x;
        last_d = draw;
      end else begin
        val_d = draw_x;
      end
    end else if (ctrl_i.draw2) begin
      lcg_d = lcg_step;
      val_d = val_q + draw_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q  <= '0;
      last_q <= '0;
    end else begin
      lcg_q  <= lcg_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule
